/* design/vw3b_pkg.sv */
// Shared types, codes and helpers of the variable weight 3x3 blur.
// Used by the stream interfaces, the blend unit and the top level; depends on nothing.
`default_nettype none
package vw3b_pkg;

    localparam int PIX_W    = 8;
    localparam int WORD_W   = 32;
    localparam int LW_W     = 11;
    localparam int CHN_W    = 3;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_PRESENT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_RGB       = 2'd3;

    // floor(x/3) for x <= 765 as (x*683) >> 11
    localparam logic [10:0] DIV3_MUL   = 11'd683;
    localparam int          DIV3_SHIFT = 11;

    localparam logic [3:0] CENTRE_IDX = 4'd4;

    typedef struct packed {
        logic [CHN_W-1:0] chan_n;   // channels in use, 1..4
        logic             alpha;
    } blend_cfg_t;

    function automatic logic [PIX_W-1:0] byte_of(input logic [WORD_W-1:0] w,
                                                 input logic [1:0] idx);
        return w[idx*PIX_W +: PIX_W];
    endfunction

    // window slot of neighbour k (centre skipped)
    function automatic logic [3:0] nb_of(input logic [2:0] k);
        logic [3:0] r;
        r = {1'b0, k};
        if (k >= 3'd4)
            r = {1'b0, k} + 4'd1;
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/vw3b_if.sv */
// Stream channels of the blur: pixel request in, result request out.
// Depends on vw3b_pkg for field widths.
`default_nettype none
interface vw3b_pix_if;
    import vw3b_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pix_c0;
    logic [PIX_W-1:0] pix_c1;
    logic [PIX_W-1:0] pix_c2;
    logic [PIX_W-1:0] pix_c3;
    logic [PIX_W-1:0] map_a;
    logic [PIX_W-1:0] map_b;
    logic [PIX_W-1:0] map_c;
    logic             pad_row;

    modport source (output valid, pix_c0, pix_c1, pix_c2, pix_c3, map_a, map_b, map_c,
                    pad_row, input ready);
    modport sink (input valid, pix_c0, pix_c1, pix_c2, pix_c3, map_a, map_b, map_c,
                  pad_row, output ready);
endinterface

interface vw3b_res_if;
    import vw3b_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_c0;
    logic [PIX_W-1:0] out_c1;
    logic [PIX_W-1:0] out_c2;
    logic [PIX_W-1:0] out_c3;
    logic             row_end;

    modport source (output valid, out_c0, out_c1, out_c2, out_c3, row_end, input ready);
    modport sink (input valid, out_c0, out_c1, out_c2, out_c3, row_end, output ready);
endinterface
`default_nettype wire

/* design/variable_weight_3x3_blur_unit.sv */
// Spatially variable 3x3 blur, top level: config registers, window
// control and result register. Depends on vw3b_pkg, vw3b_if, vw3b_line_mem, vw3b_blend.
//
// Usage: raster pixels arrive on pix_ch (valid/ready), row by row, each with
// its map pixel; after the last row send one row of requests with pad_row
// set. Output row r leaves on res_ch while input row r+1 (or the pad row)
// streams in; the last pixel of each output row carries row_end.
// An item goes through the line store read and write-back; each result it
// causes then takes the blend unit one pass per channel in use, in which a
// colour channel with alpha also runs the serial divider when its neighbour
// alpha sum is nonzero, and each unused channel is just set to zero; then the
// unit is started, its finish seen and the result register loaded, and the
// second result of a row end is first set up in T_LOADB.
// An item causes zero, one or two results.
// Reset clears the control state and the window and sets the configuration
// to its defaults; the line store holds no valid data until written and needs no clearing pass.
// A stalled receiver holds the result register; the block keeps working
// until its next result needs that register, then waits. The user must write the
// configuration (cfg_we/cfg_index/cfg_data) only while idle; the block does not check.
`default_nettype none
module variable_weight_3x3_blur_unit import vw3b_pkg::*; #(
    parameter int MAX_WIDTH      = 1024,
    parameter int BETA_FRAC_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    vw3b_pix_if.sink                  pix_ch,
    vw3b_res_if.source                res_ch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LW_W-1:0]      cfg_data
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int KW  = BETA_FRAC_BITS + 1;
    localparam int XW  = (AW + 1 > LW_W) ? AW + 1 : LW_W;
    localparam int MEMW = 2 * WORD_W + PIX_W;

    typedef logic [KW-1:0] beta_tab_t [256];

    function automatic beta_tab_t build_beta_lut();
        beta_tab_t        t;
        longint unsigned  num;
        for (int m = 0; m < 256; m++)
        begin
            num  = 64'(2 * m * m) * (64'd1 << BETA_FRAC_BITS) + 64'd65025;
            t[m] = KW'(num / 130050);
        end
        return t;
    endfunction

    localparam beta_tab_t BETA_TAB = build_beta_lut();

    typedef enum logic [2:0] {
        T_IDLE, T_READ, T_LOADB, T_RUN, T_PUT
    } tstate_t;

    tstate_t            state_reg;
    logic [LW_W-1:0]    line_width_reg;
    logic [CHN_W-1:0]   channel_count_reg;
    logic               alpha_present_reg;
    logic               map_rgb_reg;
    logic [AW-1:0]      column_pos_reg;
    logic [1:0]         rows_seen_reg;
    logic [WORD_W-1:0]  win_reg [6];
    logic [PIX_W-1:0]   centre_map_reg;
    logic [WORD_W-1:0]  pix_reg;
    logic               pad_reg;
    logic [PIX_W-1:0]   mval_reg;
    logic [WORD_W-1:0]  col_reg [9];
    logic [KW-1:0]      beta_reg;
    logic               need_b_reg;
    logic               row_end_reg;
    logic               start_reg;
    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_reg [4];
    logic               out_end_reg;

    logic [XW-1:0]      w_eff;
    logic               last;
    logic [9:0]         map_sum;
    logic [20:0]        map_prod;
    logic [PIX_W-1:0]   mval;
    logic [MEMW-1:0]    rd_data;
    logic [WORD_W-1:0]  rd_older;
    logic [WORD_W-1:0]  rd_newer;
    logic [PIX_W-1:0]   rd_map;
    logic [WORD_W-1:0]  right [3];
    logic               need_a;
    logic               need_b;
    logic               mem_we;
    logic               accept;
    logic               out_free;
    blend_cfg_t         bcfg;
    logic               blend_done;
    logic [PIX_W-1:0]   blend_res [4];

    always_comb
    begin
        w_eff = XW'(line_width_reg);
        if (w_eff == '0)
            w_eff = XW'(1);
        if (w_eff > XW'(MAX_WIDTH))
            w_eff = XW'(MAX_WIDTH);
        last = (XW'(column_pos_reg) + XW'(1)) >= w_eff;

        map_sum  = 10'(pix_ch.map_a) + 10'(pix_ch.map_b) + 10'(pix_ch.map_c);
        map_prod = 21'(map_sum) * 21'(DIV3_MUL);
        mval     = map_rgb_reg ? map_prod[DIV3_SHIFT +: PIX_W] : pix_ch.map_a;

        rd_older = rd_data[WORD_W-1:0];
        rd_newer = rd_data[2*WORD_W-1:WORD_W];
        rd_map   = rd_data[MEMW-1:2*WORD_W];
        right[0] = (rows_seen_reg == 2'd1) ? rd_newer : rd_older;
        right[1] = rd_newer;
        right[2] = pad_reg ? rd_newer : pix_reg;

        need_a = (column_pos_reg != '0) && (rows_seen_reg != 2'd0);
        need_b = last && (rows_seen_reg != 2'd0);

        bcfg.chan_n = channel_count_reg;
        if (channel_count_reg == '0)
            bcfg.chan_n = 3'd1;
        else if (channel_count_reg > 3'd4)
            bcfg.chan_n = 3'd4;
        bcfg.alpha = alpha_present_reg;
    end

    assign accept   = pix_ch.valid && pix_ch.ready;
    assign mem_we   = (state_reg == T_READ) && !pad_reg;
    assign out_free = !out_valid_reg || res_ch.ready;

    vw3b_line_mem #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (MEMW)
    ) u_line_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (column_pos_reg),
        .wdata ({mval_reg, pix_reg, rd_newer}),
        .re    (accept),
        .raddr (column_pos_reg),
        .rdata (rd_data)
    );

    vw3b_blend #(
        .BETA_FRAC_BITS (BETA_FRAC_BITS)
    ) u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .cfg   (bcfg),
        .col   (col_reg),
        .beta  (beta_reg),
        .done  (blend_done),
        .res   (blend_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= T_IDLE;
            line_width_reg    <= LW_W'(1024);
            channel_count_reg <= 3'd3;
            alpha_present_reg <= 1'b0;
            map_rgb_reg       <= 1'b0;
            column_pos_reg    <= '0;
            rows_seen_reg     <= '0;
            centre_map_reg    <= '0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
            need_b_reg        <= 1'b0;
            start_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LINE_WIDTH:    line_width_reg    <= cfg_data;
                    CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CHN_W-1:0];
                    CFG_ALPHA_PRESENT: alpha_present_reg <= cfg_data[0];
                    CFG_MAP_RGB:       map_rgb_reg       <= cfg_data[0];
                    default:           map_rgb_reg       <= map_rgb_reg;
                endcase
            end

            // drop the taken result unless a new one is loaded this cycle
            if (out_valid_reg && res_ch.ready && state_reg != T_PUT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        pix_reg   <= {pix_ch.pix_c3, pix_ch.pix_c2, pix_ch.pix_c1,
                                      pix_ch.pix_c0};
                        pad_reg   <= pix_ch.pad_row;
                        mval_reg  <= mval;
                        state_reg <= T_READ;
                    end
                end
                T_READ:
                begin
                    // snapshot the window for the inner result before it shifts
                    for (int i = 0; i < 6; i++)
                        col_reg[i] <= win_reg[i];
                    for (int i = 0; i < 3; i++)
                    begin
                        col_reg[6+i] <= right[i];
                        win_reg[3+i] <= right[i];
                        win_reg[i]   <= (column_pos_reg == '0) ? right[i] : win_reg[3+i];
                    end
                    beta_reg       <= BETA_TAB[centre_map_reg];
                    centre_map_reg <= rd_map;
                    row_end_reg    <= 1'b0;
                    need_b_reg     <= need_b;

                    if (last)
                    begin
                        column_pos_reg <= '0;
                        if (pad_reg)
                            rows_seen_reg <= 2'd0;
                        else if (rows_seen_reg != 2'd2)
                            rows_seen_reg <= rows_seen_reg + 2'd1;
                    end
                    else
                        column_pos_reg <= column_pos_reg + AW'(1);

                    if (need_a)
                    begin
                        start_reg <= 1'b1;
                        state_reg <= T_RUN;
                    end
                    else if (need_b)
                        state_reg <= T_LOADB;
                    else
                        state_reg <= T_IDLE;
                end
                T_LOADB:
                begin
                    // right column replicates the middle one
                    for (int i = 0; i < 6; i++)
                        col_reg[i] <= win_reg[i];
                    for (int i = 0; i < 3; i++)
                        col_reg[6+i] <= win_reg[3+i];
                    beta_reg    <= BETA_TAB[centre_map_reg];
                    row_end_reg <= 1'b1;
                    need_b_reg  <= 1'b0;
                    start_reg   <= 1'b1;
                    state_reg   <= T_RUN;
                end
                T_RUN:
                begin
                    if (blend_done)
                        state_reg <= T_PUT;
                end
                T_PUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= blend_res;
                        out_end_reg   <= row_end_reg;
                        state_reg     <= need_b_reg ? T_LOADB : T_IDLE;
                    end
                end
                default:
                    state_reg <= T_IDLE;
            endcase
        end
    end

    assign pix_ch.ready   = (state_reg == T_IDLE);
    assign res_ch.valid   = out_valid_reg;
    assign res_ch.out_c0  = out_reg[0];
    assign res_ch.out_c1  = out_reg[1];
    assign res_ch.out_c2  = out_reg[2];
    assign res_ch.out_c3  = out_reg[3];
    assign res_ch.row_end = out_end_reg;

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        blend_done |-> state_reg == T_RUN)
        else $error("blend finished outside of a run");

    a_rows_range: assert property (@(posedge clk) disable iff (!rst_n)
        rows_seen_reg != 2'd3)
        else $error("row count out of range");

    a_pad_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !pad_reg && $past(accept))
        else $error("line store written without a fresh request");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_ch.ready) |=> out_valid_reg && $stable(out_end_reg))
        else $error("pending result overwritten");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_READ) |-> XW'(column_pos_reg) < XW'(MAX_WIDTH))
        else $error("column position beyond line store");

endmodule
`default_nettype wire

/* design/vw3b_line_mem.sv */
// Line store: one write port, one read port with registered read data.
// Stand-alone, no package use.
`default_nettype none
module vw3b_line_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 72
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* design/vw3b_blend.sv */
// Blend unit: one output pixel, channel by channel, over multiply states and a
// bit-serial divider. Depends on vw3b_pkg.
`default_nettype none
module vw3b_blend import vw3b_pkg::*; #(
    parameter int BETA_FRAC_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire blend_cfg_t              cfg,
    input  wire logic [WORD_W-1:0]       col [9],
    input  wire logic [BETA_FRAC_BITS:0] beta,
    output      logic                    done,
    output      logic [PIX_W-1:0]        res [4]
);

    localparam int F   = BETA_FRAC_BITS;
    localparam int KW  = F + 1;
    localparam int P1W = KW + 8;
    localparam int P2W = KW + 19;
    localparam int SPW = KW + 11;
    localparam int NW  = KW + 22;
    localparam int RW  = NW - F - 1;

    typedef enum logic [2:0] {
        B_IDLE, B_CHAN, B_ACC, B_MUL1, B_MUL2, B_SUM, B_DIV, B_STORE
    } bstate_t;

    bstate_t          state_reg;
    logic [1:0]       ch_reg;
    logic [2:0]       k_reg;
    logic [10:0]      s_reg;
    logic [18:0]      x_reg;
    logic [10:0]      y_reg;
    logic [P1W-1:0]   p1_reg;
    logic [P2W-1:0]   p2_reg;
    logic [P2W-1:0]   p3_reg;
    logic [RW-1:0]    rem_reg;
    logic [8:0]       q_reg;
    logic [3:0]       i_reg;
    logic [8:0]       r_reg;
    logic             done_reg;
    logic [PIX_W-1:0] res_reg [4];

    logic [KW-1:0]     keep;
    logic [1:0]        a_idx;
    logic              use_alpha;
    logic              ch_off;
    logic [WORD_W-1:0] nb_word;
    logic [PIX_W-1:0]  nb_v;
    logic [PIX_W-1:0]  nb_a;
    logic [PIX_W-1:0]  ctr_v;
    logic [PIX_W-1:0]  ctr_a;
    logic [PIX_W-1:0]  own_v;
    logic [SPW-1:0]    plain_sum;
    logic [P1W-1:0]    zero_sum;
    logic [NW-1:0]     num_full;
    logic [RW-1:0]     div_step;
    logic [8:0]        q_next;

    always_comb
    begin
        keep      = (KW'(1) << F) - beta;
        a_idx     = 2'(cfg.chan_n - 3'd1);
        use_alpha = cfg.alpha && (ch_reg != a_idx);
        ch_off    = {1'b0, ch_reg} >= cfg.chan_n;
        nb_word   = col[nb_of(k_reg)];
        nb_v      = byte_of(nb_word, ch_reg);
        nb_a      = byte_of(nb_word, a_idx);
        ctr_v     = byte_of(col[CENTRE_IDX], ch_reg);
        ctr_a     = byte_of(col[CENTRE_IDX], a_idx);
        own_v     = use_alpha ? ((ctr_a != '0) ? ctr_v : '0) : ctr_v;
        plain_sum = (SPW'(p1_reg) << 3) + SPW'(p2_reg) + (SPW'(4) << F);
        zero_sum  = p1_reg + (P1W'(1) << (F - 1));
        num_full  = ((NW'(p3_reg) + NW'(p2_reg)) << 1) + (NW'(y_reg) << F);
        div_step  = RW'(y_reg) << i_reg;
        q_next    = q_reg;
        if (rem_reg >= div_step)
            q_next = q_reg | (9'd1 << i_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
            ch_reg    <= '0;
            k_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (start)
                    begin
                        ch_reg    <= '0;
                        state_reg <= B_CHAN;
                    end
                end
                B_CHAN:
                begin
                    if (ch_off)
                    begin
                        res_reg[ch_reg] <= '0;
                        ch_reg          <= ch_reg + 2'd1;
                        if (ch_reg == 2'd3)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= B_IDLE;
                        end
                    end
                    else
                    begin
                        s_reg     <= '0;
                        x_reg     <= '0;
                        y_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= B_ACC;
                    end
                end
                B_ACC:
                begin
                    s_reg <= s_reg + 11'(nb_v);
                    x_reg <= x_reg + 19'(nb_v) * 19'(nb_a);
                    y_reg <= y_reg + 11'(nb_a);
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == 3'd7)
                        state_reg <= B_MUL1;
                end
                B_MUL1:
                begin
                    p1_reg    <= P1W'(keep) * P1W'(own_v);
                    p2_reg    <= P2W'(beta) * (use_alpha ? P2W'(x_reg) : P2W'(s_reg));
                    state_reg <= B_MUL2;
                end
                B_MUL2:
                begin
                    if (!use_alpha)
                    begin
                        r_reg     <= plain_sum[SPW-1:F+3];
                        state_reg <= B_STORE;
                    end
                    else if (y_reg == '0)
                    begin
                        r_reg     <= zero_sum[P1W-1:F];
                        state_reg <= B_STORE;
                    end
                    else
                    begin
                        p3_reg    <= P2W'(p1_reg) * P2W'(y_reg);
                        state_reg <= B_SUM;
                    end
                end
                B_SUM:
                begin
                    rem_reg   <= num_full[NW-1:F+1];
                    q_reg     <= '0;
                    i_reg     <= 4'd8;
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    // one quotient bit per cycle, restoring
                    if (rem_reg >= div_step)
                        rem_reg <= rem_reg - div_step;
                    q_reg <= q_next;
                    i_reg <= i_reg - 4'd1;
                    if (i_reg == 4'd0)
                    begin
                        r_reg     <= q_next;
                        state_reg <= B_STORE;
                    end
                end
                B_STORE:
                begin
                    res_reg[ch_reg] <= (r_reg > 9'd255) ? 8'd255 : r_reg[7:0];
                    ch_reg          <= ch_reg + 2'd1;
                    if (ch_reg == 2'd3)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= B_IDLE;
                    end
                    else
                        state_reg <= B_CHAN;
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
`default_nettype wire
